// File: sv/mma_pkg.sv
// Shared constants, codes and helper functions of the matrix multiply-accumulate block.
package mma_pkg;

   localparam int MAX_DIM   = 8;
   localparam int ELEM_BITS = 16;
   localparam int ACC_BITS  = 48;
   localparam int PROD_BITS = 2 * ELEM_BITS;

   localparam int IDX_BITS  = 3;   // row and column fields
   localparam int DIM_BITS  = 4;   // dimension registers
   localparam int DEPTH     = MAX_DIM * MAX_DIM;
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // request codes
   localparam logic [1:0] REQ_WRITE_A   = 2'd0;
   localparam logic [1:0] REQ_WRITE_B   = 2'd1;
   localparam logic [1:0] REQ_PRELOAD_C = 2'd2;
   localparam logic [1:0] REQ_START     = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_RESULT_ROWS = 2'd0;
   localparam logic [1:0] CSR_RESULT_COLS = 2'd1;
   localparam logic [1:0] CSR_INNER_LEN   = 2'd2;

   localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(8);

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } pipe_flags_type;

   function automatic logic [ADDR_BITS-1:0] addr_of(input logic [IDX_BITS-1:0] row,
                                                     input logic [IDX_BITS-1:0] col);
      return ADDR_BITS'(int'(row) * MAX_DIM + int'(col));
   endfunction

   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] d);
      return (d > DIM_BITS'(MAX_DIM)) ? DIM_BITS'(MAX_DIM) : d;
   endfunction

   // sign-extend or wrap a 16-bit element to the stored element width
   function automatic logic signed [ELEM_BITS-1:0] elem_wrap(input logic signed [15:0] v);
      return ELEM_BITS'(v);
   endfunction

endpackage

// File: sv/mma_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module mma_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/matrix_multiply_accumulate.sv
// Top level of the dense matrix multiply-accumulate block, C += A * B.
//
// Usage
//  - req channel (valid/stall): write A (type 0), write B (type 1) or preload C (type 2)
//    at row/column index, or start (type 3). Writes give no result; a write whose index
//    is not below MAX_DIM is dropped.
//  - start walks C in row-major order over the configured rows and columns; each C
//    element is preload + sum over k of A[i][k]*B[k][j], sent on rsp with last on the
//    final one. Every emitted C entry returns to zero. Zero rows or columns: nothing.
//  - csr channel (valid/ready, always ready): index 0 rows, 1 columns, 2 inner length,
//    values above MAX_DIM are taken as MAX_DIM. Write only while idle.
//  - Timing: each element's k loop is issued by the single A/B read port pair (one k
//    per cycle), then passes through the read, multiply and accumulate stages.
//    req_stall is high from start until the last result sits in the output register.
//  - rsp stall: the finished element waits in the accumulator; the next element is
//    not issued until the output register has taken the previous one.
//  - Reset: C reads as zero (per-entry valid bits), dimensions are 8, A and B are
//    undefined until written.
module matrix_multiply_accumulate (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_type,
   input  logic [mma_pkg::IDX_BITS-1:0]         req_row_index,
   input  logic [mma_pkg::IDX_BITS-1:0]         req_col_index,
   input  logic signed [15:0]                   req_elem_value,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mma_pkg::IDX_BITS-1:0]         rsp_out_row,
   output logic [mma_pkg::IDX_BITS-1:0]         rsp_out_col,
   output logic signed [mma_pkg::ACC_BITS-1:0]  rsp_out_value,
   output logic                                 rsp_last,
   // configuration channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [1:0]                           csr_index,
   input  logic [mma_pkg::DIM_BITS-1:0]         csr_data
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_ISSUE = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;

   localparam int AB = mma_pkg::ADDR_BITS;
   localparam int IB = mma_pkg::IDX_BITS;
   localparam int DB = mma_pkg::DIM_BITS;
   localparam int EB = mma_pkg::ELEM_BITS;
   localparam int CB = mma_pkg::ACC_BITS;
   localparam int PB = mma_pkg::PROD_BITS;

   // configuration registers
   logic [DB-1:0] rows_ff, cols_ff, inner_ff;

   // sequencer
   logic [1:0]    state_ff, state_in;
   logic [IB-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [DB-1:0] nr_ff, nr_in, nc_ff, nc_in, nk_ff, nk_in;
   logic          nk_zero_ff, nk_zero_in;

   // pipeline
   mma_pkg::pipe_flags_type s1_ff, s1_in, s2_ff;
   logic                    s1_cvld_ff;
   logic signed [PB-1:0]    product_ff;
   logic [CB-1:0]           cval_ff;
   logic signed [CB-1:0]    acc_ff;
   logic                    pending_ff, pending_in;

   // C entry valid bits: an entry not valid reads as zero
   logic [mma_pkg::DEPTH-1:0] c_valid_ff;

   // output register
   logic                 rsp_valid_ff;
   logic [IB-1:0]        rsp_row_ff, rsp_col_ff;
   logic signed [CB-1:0] rsp_value_ff;
   logic                 rsp_last_ff;

   // memory ports
   logic          req_accept, wr_ok, start;
   logic          wr_a_en, wr_b_en, wr_c_en;
   logic [AB-1:0] wr_addr, a_rd_addr, b_rd_addr, c_rd_addr;
   logic [EB-1:0] a_rd_data, b_rd_data;
   logic [CB-1:0] c_rd_data;
   logic [EB-1:0] wr_elem;
   logic [CB-1:0] wr_c_data;

   logic issue, k_last, move, elem_last;

   assign csr_ready  = 1'b1;
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign start      = req_accept && (req_type == mma_pkg::REQ_START);

   assign wr_ok   = ({1'b0, req_row_index} < (IB + 1)'(mma_pkg::MAX_DIM)) &&
                    ({1'b0, req_col_index} < (IB + 1)'(mma_pkg::MAX_DIM));
   assign wr_addr = mma_pkg::addr_of(req_row_index, req_col_index);
   assign wr_elem = mma_pkg::elem_wrap(req_elem_value);
   assign wr_c_data = CB'($signed(wr_elem));

   assign wr_a_en = req_accept && wr_ok && (req_type == mma_pkg::REQ_WRITE_A);
   assign wr_b_en = req_accept && wr_ok && (req_type == mma_pkg::REQ_WRITE_B);
   assign wr_c_en = req_accept && wr_ok && (req_type == mma_pkg::REQ_PRELOAD_C);

   assign issue     = (state_ff == S_ISSUE);
   assign k_last    = nk_zero_ff || (({1'b0, k_ff} + DB'(1)) == nk_ff);
   assign a_rd_addr = mma_pkg::addr_of(i_ff, k_ff);
   assign b_rd_addr = mma_pkg::addr_of(k_ff, j_ff);
   assign c_rd_addr = mma_pkg::addr_of(i_ff, j_ff);

   // finished element moves to the output register when it is free
   assign move      = pending_ff && (!rsp_valid_ff || !rsp_stall);
   assign elem_last = (({1'b0, i_ff} + DB'(1)) == nr_ff) &&
                      (({1'b0, j_ff} + DB'(1)) == nc_ff);

   mma_ram #(.WIDTH(EB), .DEPTH(mma_pkg::DEPTH)) u_a_ram (
      .clock   (clock),
      .wr_en   (wr_a_en),
      .wr_addr (wr_addr),
      .wr_data (wr_elem),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   mma_ram #(.WIDTH(EB), .DEPTH(mma_pkg::DEPTH)) u_b_ram (
      .clock   (clock),
      .wr_en   (wr_b_en),
      .wr_addr (wr_addr),
      .wr_data (wr_elem),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   mma_ram #(.WIDTH(CB), .DEPTH(mma_pkg::DEPTH)) u_c_ram (
      .clock   (clock),
      .wr_en   (wr_c_en),
      .wr_addr (wr_addr),
      .wr_data (wr_c_data),
      .rd_addr (c_rd_addr),
      .rd_data (c_rd_data)
   );

   // sequencer next state
   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      nr_in      = nr_ff;
      nc_in      = nc_ff;
      nk_in      = nk_ff;
      nk_zero_in = nk_zero_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               nr_in      = mma_pkg::clamp_dim(rows_ff);
               nc_in      = mma_pkg::clamp_dim(cols_ff);
               nk_in      = mma_pkg::clamp_dim(inner_ff);
               nk_zero_in = (inner_ff == '0);
               i_in       = '0;
               j_in       = '0;
               k_in       = '0;
               if ((rows_ff != '0) && (cols_ff != '0)) begin
                  state_in = S_ISSUE;
               end
            end
         end
         S_ISSUE: begin
            if (k_last) begin
               state_in = S_DRAIN;
            end else begin
               k_in = k_ff + IB'(1);
            end
         end
         S_DRAIN: begin
            if (move) begin
               k_in = '0;
               if (elem_last) begin
                  state_in = S_IDLE;
               end else if (({1'b0, j_ff} + DB'(1)) == nc_ff) begin
                  j_in     = '0;
                  i_in     = i_ff + IB'(1);
                  state_in = S_ISSUE;
               end else begin
                  j_in     = j_ff + IB'(1);
                  state_in = S_ISSUE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      s1_in.valid = issue;
      s1_in.first = (k_ff == '0);
      s1_in.last  = k_last;
      pending_in  = pending_ff;
      if (s2_ff.valid && s2_ff.last) begin
         pending_in = 1'b1;
      end else if (move) begin
         pending_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rows_ff      <= mma_pkg::DIM_RESET;
         cols_ff      <= mma_pkg::DIM_RESET;
         inner_ff     <= mma_pkg::DIM_RESET;
         s1_ff        <= '0;
         s2_ff        <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         c_valid_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         s1_ff      <= s1_in;
         s2_ff      <= s1_ff;
         pending_ff <= pending_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               mma_pkg::CSR_RESULT_ROWS: rows_ff  <= csr_data;
               mma_pkg::CSR_RESULT_COLS: cols_ff  <= csr_data;
               mma_pkg::CSR_INNER_LEN:   inner_ff <= csr_data;
               default: ;
            endcase
         end
         // an emitted entry is cleared as it is first read
         if (wr_c_en) begin
            c_valid_ff[wr_addr] <= 1'b1;
         end else if (issue && (k_ff == '0)) begin
            c_valid_ff[c_rd_addr] <= 1'b0;
         end
         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      i_ff       <= i_in;
      j_ff       <= j_in;
      k_ff       <= k_in;
      nr_ff      <= nr_in;
      nc_ff      <= nc_in;
      nk_ff      <= nk_in;
      nk_zero_ff <= nk_zero_in;
      s1_cvld_ff <= c_valid_ff[c_rd_addr];
      // multiply stage, aligned with the read data
      if (nk_zero_ff) begin
         product_ff <= '0;
      end else begin
         product_ff <= PB'($signed(a_rd_data)) * PB'($signed(b_rd_data));
      end
      cval_ff <= s1_cvld_ff ? c_rd_data : '0;
      // accumulate stage
      if (s2_ff.valid) begin
         acc_ff <= (s2_ff.first ? $signed(cval_ff) : acc_ff) + CB'(product_ff);
      end
      if (move) begin
         rsp_row_ff   <= i_ff;
         rsp_col_ff   <= j_ff;
         rsp_value_ff <= acc_ff;
         rsp_last_ff  <= elem_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// File: tb/sv/matrix_multiply_accumulate_tb.sv
// Self-checking testbench for the matrix multiply-accumulate block, with a C += A*B predictor.
module matrix_multiply_accumulate_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Run limits: an overall cap on the run and the quiet wait after the results drain.
   localparam int          CYCLE_LIMIT   = 5_000_000;
   localparam int          SETTLE_CYCLES = 24;
   // index 3 of the register channel decodes to nothing
   localparam logic [1:0]  CSR_UNMAPPED  = 2'd3;

   typedef logic signed [mma_pkg::ELEM_BITS-1:0] elem_type;
   typedef logic signed [mma_pkg::PROD_BITS-1:0] prod_type;
   typedef logic signed [mma_pkg::ACC_BITS-1:0]  acc_type;

   typedef struct {
      logic [mma_pkg::IDX_BITS-1:0] row;
      logic [mma_pkg::IDX_BITS-1:0] col;
      acc_type                      value;
      logic                         last;
   } c_elem_type;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic [1:0]                          req_type;
   logic [mma_pkg::IDX_BITS-1:0]        req_row_index;
   logic [mma_pkg::IDX_BITS-1:0]        req_col_index;
   logic signed [15:0]                  req_elem_value;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic [mma_pkg::IDX_BITS-1:0]        rsp_out_row;
   logic [mma_pkg::IDX_BITS-1:0]        rsp_out_col;
   logic signed [mma_pkg::ACC_BITS-1:0] rsp_out_value;
   logic                                rsp_last;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [1:0]                          csr_index;
   logic [mma_pkg::DIM_BITS-1:0]        csr_data;

   // Predictor state: its own copy of the stores and of the dimension registers.
   elem_type                     a_mem [mma_pkg::DEPTH];
   elem_type                     b_mem [mma_pkg::DEPTH];
   acc_type                      c_mem [mma_pkg::DEPTH];
   bit                           a_written [mma_pkg::DEPTH];
   bit                           b_written [mma_pkg::DEPTH];
   logic [mma_pkg::DIM_BITS-1:0] rows_reg;
   logic [mma_pkg::DIM_BITS-1:0] cols_reg;
   logic [mma_pkg::DIM_BITS-1:0] inner_reg;

   c_elem_type            pending_c_elems [$];
   int                    mismatch_count;
   int                    items_sent;
   int                    cycle_count;
   int                    hold_off_cycles;
   bit                    send_idle_on;
   bit                    rsp_idle_on;

   matrix_multiply_accumulate uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_row_index  (req_row_index),
      .req_col_index  (req_col_index),
      .req_elem_value (req_elem_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_value  (rsp_out_value),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop: a hung handshake must not run the simulation for ever.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   // Receiver side. A requested hold-off wins over everything; otherwise random stall
   // bursts while idling is enabled. One assignment per falling edge.
   initial begin
      int burst;
      rsp_stall = 1'b0;
      burst = 0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_off_cycles--;
         end else if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 6) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Result checker: every accepted result transaction is matched against the oldest
   // expected C element, field by field.
   always @(posedge clock) begin
      c_elem_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_c_elems.size() == 0) begin
            $error("unexpected result: row %0d col %0d value %0d", rsp_out_row, rsp_out_col,
                   rsp_out_value);
            mismatch_count++;
         end else begin
            want = pending_c_elems.pop_front();
            if (rsp_out_row !== want.row) begin
               $error("out_row: expected %0d, actual %0d", want.row, rsp_out_row);
               mismatch_count++;
            end
            if (rsp_out_col !== want.col) begin
               $error("out_col: expected %0d, actual %0d", want.col, rsp_out_col);
               mismatch_count++;
            end
            if (rsp_out_value !== want.value) begin
               $error("out_value: expected %0d, actual %0d", want.value, rsp_out_value);
               mismatch_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, actual %0b", want.last, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   // Dimension register as the datapath sees it: anything above MAX_DIM saturates.
   function automatic int effective_dim(input logic [mma_pkg::DIM_BITS-1:0] d);
      return (int'(d) > mma_pkg::MAX_DIM) ? mma_pkg::MAX_DIM : int'(d);
   endfunction

   // Mostly small sizes to keep the run short; zero, the full size and oversize values
   // appear now and then.
   function automatic int pick_dim();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0)
         return 0;
      else if (roll < 15)
         return $urandom_range(1, 4);
      else if (roll < 18)
         return $urandom_range(5, 8);
      else
         return $urandom_range(9, 15);
   endfunction

   function automatic logic [15:0] operand_value(input bit extreme);
      if (extreme)
         return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      return 16'($urandom);
   endfunction

   function automatic logic [1:0] write_kind();
      case ($urandom_range(0, 2))
         0:       return mma_pkg::REQ_WRITE_A;
         1:       return mma_pkg::REQ_WRITE_B;
         default: return mma_pkg::REQ_PRELOAD_C;
      endcase
   endfunction

   // Applies one accepted request transaction to the predicted stores. A start walks C
   // in row-major order, queues each element with its preload plus dot product and
   // clears the emitted C entry.
   task automatic update_stores_and_emit(input logic [1:0] kind,
                                         input logic [mma_pkg::IDX_BITS-1:0] r,
                                         input logic [mma_pkg::IDX_BITS-1:0] c,
                                         input logic [15:0] raw);
      elem_type   v;
      acc_type    acc;
      prod_type   p;
      c_elem_type e;
      int         addr;
      int         nr;
      int         nc;
      int         nk;
      v    = elem_type'($signed(raw));
      addr = int'(r) * mma_pkg::MAX_DIM + int'(c);
      case (kind)
         mma_pkg::REQ_WRITE_A: begin
            a_mem[addr]     = v;
            a_written[addr] = 1'b1;
         end
         mma_pkg::REQ_WRITE_B: begin
            b_mem[addr]     = v;
            b_written[addr] = 1'b1;
         end
         mma_pkg::REQ_PRELOAD_C: begin
            c_mem[addr] = acc_type'(v);
         end
         default: begin
            nr = effective_dim(rows_reg);
            nc = effective_dim(cols_reg);
            nk = effective_dim(inner_reg);
            for (int i = 0; i < nr; i++) begin
               for (int j = 0; j < nc; j++) begin
                  acc = c_mem[i * mma_pkg::MAX_DIM + j];
                  for (int k = 0; k < nk; k++) begin
                     p   = prod_type'(a_mem[i * mma_pkg::MAX_DIM + k]) *
                           prod_type'(b_mem[k * mma_pkg::MAX_DIM + j]);
                     acc = acc + acc_type'(p);
                  end
                  c_mem[i * mma_pkg::MAX_DIM + j] = '0;
                  e.row   = mma_pkg::IDX_BITS'(i);
                  e.col   = mma_pkg::IDX_BITS'(j);
                  e.value = acc;
                  e.last  = (i == nr - 1) && (j == nc - 1);
                  pending_c_elems.push_back(e);
               end
            end
         end
      endcase
   endtask

   // Sends one request transaction, with an optional idle gap in front of it. Fields
   // change at the falling edge; acceptance is seen at the rising edge with stall low.
   task automatic send_request(input logic [1:0] kind,
                               input logic [mma_pkg::IDX_BITS-1:0] r,
                               input logic [mma_pkg::IDX_BITS-1:0] c,
                               input logic [15:0] value);
      if (send_idle_on && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_row_index  <= r;
      req_col_index  <= c;
      req_elem_value <= value;
      do @(posedge clock); while (req_stall);
      update_stores_and_emit(kind, r, c, value);
      items_sent++;
   endtask

   // Sender pause: nothing offered until every queued C element has come back, then a
   // few quiet cycles in case the last start produced nothing but is still running.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_c_elems.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx,
                                 input logic [mma_pkg::DIM_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         mma_pkg::CSR_RESULT_ROWS: rows_reg  = value;
         mma_pkg::CSR_RESULT_COLS: cols_reg  = value;
         mma_pkg::CSR_INNER_LEN:   inner_reg = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Registers only change with the block idle.
   task automatic write_dims(input int rows, input int cols, input int inner);
      drain_results();
      write_register(mma_pkg::CSR_RESULT_ROWS, mma_pkg::DIM_BITS'(rows));
      write_register(mma_pkg::CSR_RESULT_COLS, mma_pkg::DIM_BITS'(cols));
      write_register(mma_pkg::CSR_INNER_LEN, mma_pkg::DIM_BITS'(inner));
   endtask

   // A and B entries are undefined until written, so every entry the next start will
   // read is loaded first. With extreme set, all of them are rewritten at full scale.
   task automatic load_operands(input bit extreme);
      int nr;
      int nc;
      int nk;
      nr = effective_dim(rows_reg);
      nc = effective_dim(cols_reg);
      nk = effective_dim(inner_reg);
      if (nr == 0 || nc == 0)
         return;
      for (int i = 0; i < nr; i++)
         for (int k = 0; k < nk; k++)
            if (extreme || !a_written[i * mma_pkg::MAX_DIM + k])
               send_request(mma_pkg::REQ_WRITE_A, mma_pkg::IDX_BITS'(i),
                            mma_pkg::IDX_BITS'(k), operand_value(extreme));
      for (int k = 0; k < nk; k++)
         for (int j = 0; j < nc; j++)
            if (extreme || !b_written[k * mma_pkg::MAX_DIM + j])
               send_request(mma_pkg::REQ_WRITE_B, mma_pkg::IDX_BITS'(k),
                            mma_pkg::IDX_BITS'(j), operand_value(extreme));
   endtask

   task automatic random_write();
      send_request(write_kind(), mma_pkg::IDX_BITS'($urandom_range(0, 7)),
                   mma_pkg::IDX_BITS'($urandom_range(0, 7)), 16'($urandom));
   endtask

   // A well-formed sequence: a few element writes, the missing operands, then a start
   // carrying random (ignored) index and value fields.
   task automatic random_sequence();
      repeat ($urandom_range(0, 6)) random_write();
      load_operands(1'b0);
      send_request(mma_pkg::REQ_START, mma_pkg::IDX_BITS'($urandom_range(0, 7)),
                   mma_pkg::IDX_BITS'($urandom_range(0, 7)), 16'($urandom));
   endtask

   // Corner cases at the smallest size: full-scale negative operands, preload sign
   // extension, empty dot product, zero rows or columns, and a second start that must
   // see the cleared accumulator.
   task automatic test_directed_corners();
      write_dims(1, 1, 1);
      send_request(mma_pkg::REQ_WRITE_A, 3'd0, 3'd0, 16'h8000);
      send_request(mma_pkg::REQ_WRITE_B, 3'd0, 3'd0, 16'h8000);
      send_request(mma_pkg::REQ_PRELOAD_C, 3'd0, 3'd0, 16'h7fff);
      send_request(mma_pkg::REQ_START, 3'd7, 3'd7, 16'hffff);
      send_request(mma_pkg::REQ_START, 3'd0, 3'd0, 16'h0000);
      // empty dot product: result is the preload alone
      write_dims(1, 1, 0);
      send_request(mma_pkg::REQ_PRELOAD_C, 3'd0, 3'd0, 16'h8000);
      send_request(mma_pkg::REQ_START, 3'd0, 3'd0, 16'h0000);
      // zero rows, then zero columns: start emits nothing and leaves C alone
      write_dims(0, 1, 1);
      send_request(mma_pkg::REQ_PRELOAD_C, 3'd0, 3'd0, 16'h1234);
      send_request(mma_pkg::REQ_START, 3'd0, 3'd0, 16'h0000);
      write_dims(1, 0, 1);
      send_request(mma_pkg::REQ_START, 3'd0, 3'd0, 16'h0000);
      write_dims(1, 1, 1);
      send_request(mma_pkg::REQ_START, 3'd0, 3'd0, 16'h0000);
      // far corner of the stores
      send_request(mma_pkg::REQ_WRITE_A, 3'd7, 3'd7, 16'h7fff);
      send_request(mma_pkg::REQ_WRITE_B, 3'd7, 3'd7, 16'h8001);
      send_request(mma_pkg::REQ_PRELOAD_C, 3'd7, 3'd7, 16'h7fff);
   endtask

   // Full and oversize dimensions with full-scale operands, plus a write to the
   // unmapped register index which must change nothing.
   task automatic test_full_size();
      write_dims(15, 15, 15);
      write_register(CSR_UNMAPPED, 4'd1);
      load_operands(1'b1);
      send_request(mma_pkg::REQ_PRELOAD_C, 3'd0, 3'd0, 16'h7fff);
      send_request(mma_pkg::REQ_PRELOAD_C, 3'd7, 3'd0, 16'h8000);
      send_request(mma_pkg::REQ_START, 3'd0, 3'd0, 16'h0000);
      write_dims(8, 1, 8);
      send_request(mma_pkg::REQ_START, 3'd0, 3'd0, 16'h0000);
      write_dims(1, 8, 9);
      send_request(mma_pkg::REQ_START, 3'd0, 3'd0, 16'h0000);
   endtask

   // The receiver stops for a long stretch while the sender keeps offering transactions,
   // so the result path fills and the request side stalls. Then the sender waits for
   // everything to come back before carrying on.
   task automatic test_backpressure();
      write_dims(4, 4, 3);
      load_operands(1'b0);
      hold_off_cycles = 160;
      send_request(mma_pkg::REQ_START, 3'd0, 3'd0, 16'h0000);
      repeat (6) random_write();
      load_operands(1'b0);
      send_request(mma_pkg::REQ_START, 3'd0, 3'd0, 16'h0000);
      drain_results();
      send_request(mma_pkg::REQ_START, 3'd0, 3'd0, 16'h0000);
   endtask

   // Mostly well-formed sequences with random content; every tenth or so is a burst of
   // plain writes. Dimensions change every third sequence.
   task automatic test_random_traffic(input int n_items);
      int goal;
      int seq;
      goal = items_sent + n_items;
      seq  = 0;
      while (items_sent < goal) begin
         if (seq % 3 == 0) begin
            write_dims(pick_dim(), pick_dim(), pick_dim());
            if ($urandom_range(0, 7) == 0)
               write_register(CSR_UNMAPPED, mma_pkg::DIM_BITS'($urandom));
         end
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 8)) random_write();
         else
            random_sequence();
         seq++;
      end
   endtask

   // Closing stretch with no idling on either side.
   task automatic test_no_idle();
      send_idle_on = 1'b0;
      rsp_idle_on  = 1'b0;
      test_random_traffic(40);
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = mma_pkg::REQ_WRITE_A;
      req_row_index  = '0;
      req_col_index  = '0;
      req_elem_value = '0;
      csr_valid      = 1'b0;
      csr_index      = mma_pkg::CSR_RESULT_ROWS;
      csr_data       = '0;
      mismatch_count = 0;
      items_sent     = 0;
      hold_off_cycles = 0;
      send_idle_on   = 1'b1;
      rsp_idle_on    = 1'b1;
      rows_reg       = mma_pkg::DIM_RESET;
      cols_reg       = mma_pkg::DIM_RESET;
      inner_reg      = mma_pkg::DIM_RESET;
      for (int n = 0; n < mma_pkg::DEPTH; n++) begin
         a_mem[n]     = '0;
         b_mem[n]     = '0;
         c_mem[n]     = '0;
         a_written[n] = 1'b0;
         b_written[n] = 1'b0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_corners();
      test_full_size();
      test_backpressure();
      test_random_traffic(110);
      test_no_idle();

      drain_results();
      if (mismatch_count == 0 && pending_c_elems.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
